>>> rtl/ahd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahd_pkg
// shared widths, character codes and types for the ascii hex/decimal parser
// ----------------------------------------------------------------------------
package ahd_pkg;

  localparam int CharWidth  = 8;
  localparam int ValueWidth = 32;
  localparam int DigitWidth = 4;
  localparam int PosWidth   = 2;

  localparam logic [CharWidth-1:0] CHAR_NUL  = 8'h00;
  localparam logic [CharWidth-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CharWidth-1:0] CHAR_LX   = 8'h78;
  localparam logic [CharWidth-1:0] CHAR_UX   = 8'h58;

  // decoded digit of the current base
  typedef struct packed {
    logic                  valid;
    logic [DigitWidth-1:0] value;
  } digit_t;

  // request held in the input register, handed to the parse core
  typedef struct packed {
    logic                 valid;
    logic [CharWidth-1:0] char_code;
  } char_req_t;

endpackage

>>> rtl/ahd_digit_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahd_digit_decode
// maps a character to its digit value in decimal or hexadecimal
// ----------------------------------------------------------------------------
module ahd_digit_decode (
  input  logic [ahd_pkg::CharWidth-1:0] char_code,
  input  logic                          hex_mode,
  output ahd_pkg::digit_t               digit
);

  localparam logic [ahd_pkg::CharWidth-1:0] CharNine = 8'h39;
  localparam logic [ahd_pkg::CharWidth-1:0] CharLa   = 8'h61;
  localparam logic [ahd_pkg::CharWidth-1:0] CharLf   = 8'h66;
  localparam logic [ahd_pkg::CharWidth-1:0] CharUa   = 8'h41;
  localparam logic [ahd_pkg::CharWidth-1:0] CharUf   = 8'h46;
  localparam logic [ahd_pkg::CharWidth-1:0] Ten      = 8'd10;

  logic [ahd_pkg::CharWidth-1:0] offset;

  always_comb begin
    digit.valid = 1'b0;
    offset      = '0;
    if (char_code inside {[ahd_pkg::CHAR_ZERO:CharNine]}) begin
      digit.valid = 1'b1;
      offset      = char_code - ahd_pkg::CHAR_ZERO;
    end else if (hex_mode && (char_code inside {[CharLa:CharLf]})) begin
      digit.valid = 1'b1;
      offset      = char_code - CharLa + Ten;
    end else if (hex_mode && (char_code inside {[CharUa:CharUf]})) begin
      digit.valid = 1'b1;
      offset      = char_code - CharUa + Ten;
    end
    digit.value = offset[ahd_pkg::DigitWidth-1:0];
  end

endmodule

>>> rtl/ahd_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahd_parse_core
// parse state, shift-add accumulate and the result register
// ----------------------------------------------------------------------------
module ahd_parse_core (
  input  logic                           clk,
  input  logic                           rst,
  input  ahd_pkg::char_req_t             req,
  output logic                           advance,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ahd_pkg::ValueWidth-1:0] m_tdata,
  output logic                           m_tuser
);

  localparam logic [ahd_pkg::PosWidth-1:0] PosOne = 2'd1;
  localparam logic [ahd_pkg::PosWidth-1:0] PosTwo = 2'd2;

  logic [ahd_pkg::ValueWidth-1:0] accumulator, accumulator_next;
  logic [ahd_pkg::PosWidth-1:0]   position, position_next;
  logic                           first_was_zero, first_was_zero_next;
  logic                           hex_mode, hex_mode_next;
  logic                           error_seen, error_seen_next;

  ahd_pkg::digit_t                digit;
  logic                           is_term;
  logic                           is_prefix;
  logic [ahd_pkg::ValueWidth-1:0] scaled;

  ahd_digit_decode u_decode (
    .char_code (req.char_code),
    .hex_mode  (hex_mode),
    .digit     (digit)
  );

  assign is_term   = (req.char_code == ahd_pkg::CHAR_NUL);
  assign is_prefix = (position == PosOne) && first_was_zero && !hex_mode &&
                     ((req.char_code == ahd_pkg::CHAR_LX) ||
                      (req.char_code == ahd_pkg::CHAR_UX));
  // times 16 or times 10 by shifts
  assign scaled    = hex_mode ? (accumulator << 4)
                              : ((accumulator << 3) + (accumulator << 1));

  // a terminator needs a free result register
  assign advance = req.valid && (!is_term || !m_tvalid || m_tready);

  always_comb begin
    accumulator_next    = accumulator;
    position_next       = position;
    first_was_zero_next = first_was_zero;
    hex_mode_next       = hex_mode;
    error_seen_next     = error_seen;
    if (is_term) begin
      accumulator_next    = '0;
      position_next       = '0;
      first_was_zero_next = 1'b0;
      hex_mode_next       = 1'b0;
      error_seen_next     = 1'b0;
    end else begin
      if (is_prefix) begin
        hex_mode_next    = 1'b1;
        accumulator_next = '0;
      end else begin
        if (!digit.valid) begin
          error_seen_next = 1'b1;
        end else begin
          accumulator_next = scaled +
            {{(ahd_pkg::ValueWidth-ahd_pkg::DigitWidth){1'b0}}, digit.value};
        end
        if ((position == '0) && (req.char_code == ahd_pkg::CHAR_ZERO)) begin
          first_was_zero_next = 1'b1;
        end
      end
      if (position != PosTwo) begin
        position_next = position + PosOne;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator    <= '0;
      position       <= '0;
      first_was_zero <= 1'b0;
      hex_mode       <= 1'b0;
      error_seen     <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (advance) begin
        accumulator    <= accumulator_next;
        position       <= position_next;
        first_was_zero <= first_was_zero_next;
        hex_mode       <= hex_mode_next;
        error_seen     <= error_seen_next;
      end
      if (advance && is_term) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_term) begin
      m_tdata <= error_seen ? '0 : accumulator;
      m_tuser <= error_seen;
    end
  end

endmodule

>>> rtl/ascii_hex_dec_to_int.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_hex_dec_to_int
// streaming ascii string to unsigned 32-bit integer, hex (0x/0X) or decimal
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one character byte per request, a zero byte ends the string
//   m_* channel: one request per string, sent for each terminator only
//     m_tdata is the value modulo 2^32 (zero when a bad character was seen),
//     m_tuser flags a character that is not a digit of the chosen base
//   a string that opens with 0x or 0X is hex (either letter case), else decimal
//   throughput: one character per cycle unless a terminator waits on a full
//     result register, set by the combinational shift-add accumulate
//     between the input register and the parse state; results are registered
//   reset (rst, synchronous): clears the input register valid bit, the parse
//     state and m_tvalid; s_tready is high from the first cycle after reset
//   receiver stall: the result register holds its request; characters keep
//     flowing until a second terminator reaches the parse stage, which then
//     waits and backs up the input register, pulling s_tready low
//   all parse state clears after each terminator
// ----------------------------------------------------------------------------
module ascii_hex_dec_to_int (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ahd_pkg::CharWidth-1:0]  s_tdata,   // [7:0] char_code
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ahd_pkg::ValueWidth-1:0] m_tdata,   // [31:0] value
  output logic                           m_tuser    // [0] bad_character
);

  // input register between the slave port and the parse core
  ahd_pkg::char_req_t req;
  logic               advance;

  // take a new character when the register is empty or drains this cycle
  assign s_tready = !req.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (s_tready) begin
      req.valid <= s_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req.char_code <= s_tdata;
    end
  end

  ahd_parse_core u_core (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // a bad-character result always carries a zero value
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == '0))
    else $error("bad character result with nonzero value");

  // backpressure only comes from a stalled terminator in the input register
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> req.valid && (req.char_code == ahd_pkg::CHAR_NUL) &&
                  m_tvalid && !m_tready)
    else $error("input stalled without a blocked terminator");

  // a non-terminator in the input register always moves on
  assert property (@(posedge clk) disable iff (rst)
    req.valid && (req.char_code != ahd_pkg::CHAR_NUL) |-> advance)
    else $error("character held in input register");

  // a result appears only after a terminator has left the input register
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(req.valid && (req.char_code == ahd_pkg::CHAR_NUL)))
    else $error("result without terminator");

endmodule
